// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape package
// Shared types, register indexes, fixed-point constants and the log2 table.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FracBits   = 28;
  localparam int ZW         = 32;              // Q4.FracBits component width
  localparam int MulW       = 33;              // shared multiplier operand width
  localparam int ProdW      = 2 * MulW;
  localparam int TblBits    = 8;
  localparam int TblSize    = 1 << TblBits;
  localparam int FracMaxQ16 = 65470;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_REAL = 3'd0;
  localparam logic [2:0] REG_CENTER_IMAG = 3'd1;
  localparam logic [2:0] REG_PIXEL_STEP  = 3'd2;
  localparam logic [2:0] REG_WIDTH       = 3'd3;
  localparam logic [2:0] REG_HEIGHT      = 3'd4;
  localparam logic [2:0] REG_LIMIT       = 3'd5;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [15:0] iter_count;
    logic [7:0]  smooth_frac;
  } out_t;

  // log2(1 + m / TblSize) in Q16 by repeated squaring, built at elaboration
  function automatic logic [TblSize*16-1:0] build_log_tbl();
    logic [TblSize*16-1:0] t;
    logic [63:0]           x;
    logic [15:0]           r;
    t = '0;
    for (int m = 0; m < TblSize; m++) begin
      x = 64'(TblSize + m) << (30 - TblBits);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          x    = x >> 1;
        end
      end
      t[m*16 +: 16] = r;
    end
    return t;
  endfunction

  localparam logic [TblSize*16-1:0] LOG_TBL = build_log_tbl();

  // saturate a wide signed value to the 32 bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sd2147483647;
    lo = -52'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/mandelbrot_escape_smooth.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape time with smooth fraction
// One pixel in, its escape count and smooth color fraction out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one pixel index.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns the
//   escape iteration count and the smooth fraction for that pixel.
//   The user writes configuration registers through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle; the block does not enforce this.
//   Unknown indexes are ignored.
// Sequence:
//   A pixel goes through coordinate setup (S_CX, S_CY, S_CZ), then iterations
//   of three products on the single shared multiplier plus check and update
//   (the last iteration ends at its check), the fraction on escape, and the
//   hand-over of the result. The default limit is 256. The next pixel is taken
//   once the result is handed over; one finished result may wait in the output
//   register meanwhile.
// Reset and stall:
//   Reset restores the default view and drops any pending transaction.
//   A stalled receiver holds the result; the block waits before reloading.
// ----------------------------------------------------------------------------
module mandelbrot_escape_smooth
  import mbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CX   = 4'd1;
  localparam logic [3:0] S_CY   = 4'd2;
  localparam logic [3:0] S_CZ   = 4'd3;
  localparam logic [3:0] S_MR   = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_MX   = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_LOG  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // configuration
  logic [31:0] center_re_q, center_im_q;
  logic [30:0] step_q;
  logic [15:0] width_q, height_q, limit_q;

  logic [3:0]  state_d, state_q;
  logic [15:0] px_q, py_q;
  logic signed [ZW-1:0] re_d, re_q, im_d, im_q, zr_d, zr_q, zi_d, zi_q;
  logic [15:0] it_d, it_q;
  logic [7:0]  fr_d, fr_q;
  logic [63:0] sr_d, sr_q;
  logic signed [63:0] dr_d, dr_q;
  logic        ov_d, ov_q;
  out_t        od_d, od_q;

  logic signed [MulW-1:0]  ma, mb;
  logic signed [ProdW-1:0] prod;
  logic signed [17:0] offx, offy;
  logic signed [51:0] cval;
  logic [63:0] sum;
  logic        esc;
  logic        frac_start, frac_done;
  logic [7:0]  frac_val;
  logic [16:0] it_next;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  mbe_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (frac_start),
    .sum_i   (sum),
    .done_o  (frac_done),
    .frac_o  (frac_val)
  );

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= '0;
      center_im_q <= '0;
      step_q      <= 31'd2097152;
      width_q     <= 16'd640;
      height_q    <= 16'd480;
      limit_q     <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_REAL: center_re_q <= cfg_data_i;
        REG_CENTER_IMAG: center_im_q <= cfg_data_i;
        REG_PIXEL_STEP:  step_q      <= cfg_data_i[30:0];
        REG_WIDTH:       width_q     <= cfg_data_i[15:0];
        REG_HEIGHT:      height_q    <= cfg_data_i[15:0];
        REG_LIMIT:       limit_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // centered offsets and the coordinate from the product
  assign offx = $signed({1'b0, px_q, 1'b0}) - $signed({2'b0, width_q});
  assign offy = $signed({1'b0, py_q, 1'b0}) - $signed({2'b0, height_q});
  assign cval = ($signed(prod[51:0]) >>> 1) +
                ((state_q == S_CY) ? 52'(signed'(center_re_q)) :
                                     52'(signed'(center_im_q)));

  assign sum     = sr_q + 64'(prod);
  assign esc     = sum > (64'd1 << (2 * FracBits + 2));
  assign it_next = {1'b0, it_q} + 17'd1;

  // multiplier operand select
  always_comb begin
    case (state_q)
      S_CX:    begin ma = MulW'(offx); mb = $signed({2'b0, step_q}); end
      S_CY:    begin ma = MulW'(offy); mb = $signed({2'b0, step_q}); end
      S_MR:    begin ma = MulW'(zr_q); mb = MulW'(zr_q); end
      S_MI:    begin ma = MulW'(zi_q); mb = MulW'(zi_q); end
      S_MX:    begin ma = MulW'(zr_q); mb = MulW'(zi_q); end
      default: begin ma = MulW'(zr_q); mb = MulW'(zi_q); end
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    re_d       = re_q;
    im_d       = im_q;
    zr_d       = zr_q;
    zi_d       = zi_q;
    it_d       = it_q;
    fr_d       = fr_q;
    sr_d       = sr_q;
    dr_d       = dr_q;
    frac_start = 1'b0;
    ov_d       = ov_q;
    od_d       = od_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CX;
      end
      S_CX: state_d = S_CY;
      S_CY: begin
        re_d    = sat32(cval);
        state_d = S_CZ;
      end
      S_CZ: begin
        im_d = sat32(cval);
        zr_d = re_q;
        zi_d = sat32(cval);
        it_d = '0;
        fr_d = '0;
        if (limit_q == '0) state_d = S_OUT;
        else state_d = S_MR;
      end
      S_MR: state_d = S_MI;
      S_MI: begin
        sr_d    = 64'(prod);
        state_d = S_CHK;
      end
      S_CHK: begin
        dr_d = signed'(sr_q) - 64'(prod);
        if (esc) begin
          frac_start = 1'b1;
          state_d    = S_LOG;
        end else if (it_next >= {1'b0, limit_q}) begin
          it_d    = limit_q;
          state_d = S_OUT;
        end else begin
          it_d    = it_next[15:0];
          state_d = S_MX;
        end
      end
      S_MX: state_d = S_UPD;
      S_UPD: begin
        zr_d    = sat32(52'(dr_q >>> FracBits) + 52'(re_q));
        zi_d    = sat32(52'($signed(prod[63:0]) >>> (FracBits - 1)) + 52'(im_q));
        state_d = S_MR;
      end
      S_LOG: begin
        if (frac_done) begin
          fr_d    = frac_val;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          od_d    = '{iter_count: it_q, smooth_frac: fr_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers; capture the pixel on accept
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      px_q <= in_data_i.pixel_x;
      py_q <= in_data_i.pixel_y;
    end
    re_q <= re_d;
    im_q <= im_d;
    zr_q <= zr_d;
    zi_q <= zi_d;
    it_q <= it_d;
    fr_q <= fr_d;
    sr_q <= sr_d;
    dr_q <= dr_d;
    od_q <= od_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ----- rtl/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 33 multiply with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module mbe_mul
  import mbe_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  // register the product
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/mbe_frac.sv -----
// ----------------------------------------------------------------------------
// Smooth fraction unit
// Three-step log2(log2|z|^2) evaluation from the escape magnitude.
// ----------------------------------------------------------------------------
module mbe_frac
  import mbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] sum_i,
  output logic        done_o,
  output logic [7:0]  frac_o
);

  logic [2:0]  vld_q;
  logic [18:0] lq_d, lq_q;
  logic [17:0] l2_d, l2_q;
  logic [7:0]  frac_d, frac_q;
  logic [5:0]  p;
  logic [63:0] sh;
  logic [7:0]  m1, m2;
  logic [18:0] sh2;
  logic signed [18:0] f;
  logic [15:0] fc;
  logic [23:0] prod;

  // first log: leading one lies between bits 58 and 63 on escape
  always_comb begin
    p = 6'd58;
    for (int k = 59; k < 64; k++) begin
      if (sum_i[k]) p = 6'(k);
    end
    sh   = sum_i >> (p - 6'(TblBits));
    m1   = sh[7:0];
    lq_d = {3'(p - 6'd56), 16'd0} + 19'(LOG_TBL[m1*16 +: 16]);
  end

  // second log: leading one of lq is bit 17 or 18
  always_comb begin
    sh2  = lq_q[18] ? (lq_q >> 10) : (lq_q >> 9);
    m2   = sh2[7:0];
    l2_d = (lq_q[18] ? 18'h20000 : 18'h10000) + 18'(LOG_TBL[m2*16 +: 16]);
  end

  // clamp and scale by 255
  always_comb begin
    f = 19'sd131072 - $signed({1'b0, l2_q});
    if (f < 0) fc = '0;
    else if (f > 19'sd65470) fc = 16'(FracMaxQ16);
    else fc = f[15:0];
    prod   = {fc, 8'd0} - 24'(fc);
    frac_d = prod[23:16];
  end

  // advance the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lq_q   <= lq_d;
    l2_q   <= l2_d;
    frac_q <= frac_d;
  end

  assign done_o = vld_q[2];
  assign frac_o = frac_q;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape time testbench
// Streams pixels through the block under several views and iteration limits,
// predicts each escape count and smooth fraction in fixed point if not typed,
// and checks each result in order, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mbe_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam longint      ZMax       = (64'sd1 <<< 31) - 1;
  localparam longint      ZMin       = -ZMax - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  // view and limit as the block should hold them
  logic signed [31:0] view_center_re;
  logic signed [31:0] view_center_im;
  logic [30:0]        view_step;
  logic [15:0]        view_width;
  logic [15:0]        view_height;
  logic [15:0]        view_limit;

  int unsigned log2_q16 [TblSize];
  out_t        pending_pixels [$];
  int          mismatch_cnt;
  int unsigned cycle_cnt;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    bit          typed;
    logic [15:0] iter;
    logic [7:0]  frac;
  } pixel_row_t;

  mandelbrot_escape_smooth u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // log2(1 + m/256) in Q16 by repeated squaring of a Q30 mantissa
  function automatic void fill_log_table();
    logic [63:0]  x;
    int unsigned  r;
    for (int m = 0; m < TblSize; m++) begin
      x = 64'(TblSize + m) << (30 - TblBits);
      r = 0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      log2_q16[m] = r;
    end
  endfunction

  function automatic int lead_one(logic [127:0] v);
    for (int b = 127; b >= 0; b--) begin
      if (v[b]) return b;
    end
    return 0;
  endfunction

  // pixel index to Q4.28 coordinate, offset exact, sum saturated
  function automatic longint pixel_to_plane(logic [15:0] pix, logic [15:0] size,
                                            logic signed [31:0] center);
    longint off2;
    longint c;
    off2 = 2 * longint'(pix) - longint'(size);
    c = longint'(center) + ((off2 * longint'(view_step)) >>> 1);
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c;
  endfunction

  function automatic longint clamp_z(longint v);
    if (v > ZMax) return ZMax;
    if (v < ZMin) return ZMin;
    return v;
  endfunction

  function automatic out_t predict_escape(logic [15:0] px, logic [15:0] py);
    longint             re, im, zr, zi;
    logic signed [127:0] a, b, t;
    logic [127:0]        mag2;
    logic [16:0]         n;
    bit                  escaped;
    int                  p, q;
    longint              lq, l2, f;
    out_t                res;
    re = pixel_to_plane(px, view_width, view_center_re);
    im = pixel_to_plane(py, view_height, view_center_im);
    zr = 0;
    zi = 0;
    n = 0;
    escaped = 0;
    mag2 = '0;
    while (n < view_limit) begin
      a = zr;
      b = zi;
      t = (a * a - b * b) >>> FracBits;
      zr = clamp_z(longint'(t[63:0]) + re);
      t = (a * b) >>> (FracBits - 1);
      zi = clamp_z(longint'(t[63:0]) + im);
      a = zr;
      b = zi;
      mag2 = a * a + b * b;
      if (mag2 > (128'd1 << 58)) begin
        escaped = 1;
        break;
      end
      n++;
    end
    res.smooth_frac = '0;
    if (!escaped) begin
      res.iter_count = view_limit;
    end else begin
      res.iter_count = n[15:0];
      p = lead_one(mag2);
      lq = (longint'(p - 2 * FracBits) <<< 16)
           + log2_q16[(mag2 >> (p - TblBits)) & 128'hFF];
      q = lead_one(128'(lq));
      l2 = (longint'(q - 16) <<< 16) + log2_q16[(lq >> (q - TblBits)) & 64'hFF];
      f = 64'sd131072 - l2;
      if (f < 0) f = 0;
      if (f > FracMaxQ16) f = FracMaxQ16;
      res.smooth_frac = 8'((f * 255) >> 16);
    end
    return res;
  endfunction

  // wait until every result is back, then let the block settle
  task automatic drain_results();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_CENTER_REAL: view_center_re = data;
      REG_CENTER_IMAG: view_center_im = data;
      REG_PIXEL_STEP:  view_step      = data[30:0];
      REG_WIDTH:       view_width     = data[15:0];
      REG_HEIGHT:      view_height    = data[15:0];
      REG_LIMIT:       view_limit     = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_view(logic [31:0] cr, logic [31:0] ci, logic [31:0] st,
                          logic [31:0] w, logic [31:0] h, logic [31:0] lim);
    drain_results();
    write_reg(REG_CENTER_REAL, cr);
    write_reg(REG_CENTER_IMAG, ci);
    write_reg(REG_PIXEL_STEP, st);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_LIMIT, lim);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid for the gap only when there is one, so valid stays high
  // between back-to-back transactions
  task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit typed,
                            out_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_data_i.pixel_x <= px;
    in_data_i.pixel_y <= py;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_pixels.push_back(typed ? typed_res : predict_escape(px, py));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // advance the cycle counter, end the run on a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) < 70) ||
                        ($urandom_range(0, 99) < 30 && out_ready_i);
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.iter_count !== want.iter_count ||
            out_data_o.smooth_frac !== want.smooth_frac) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: iter exp %0d got %0d, frac exp %0d got %0d",
                     want.iter_count, out_data_o.iter_count,
                     want.smooth_frac, out_data_o.smooth_frac);
        end
      end
    end
  end

  initial begin
    pixel_row_t rows [$];
    out_t       typed_res;
    int         lim_pick [7];
    logic [15:0] w, h, px, py;
    logic [31:0] cr, ci, st, lim;
    lim_pick = '{1, 2, 8, 16, 24, 32, 48};
    fill_log_table();
    cycle_cnt      = 0;
    mismatch_cnt   = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    view_center_re = 0;
    view_center_im = 0;
    view_step      = 31'd2097152;
    view_width     = 16'd640;
    view_height    = 16'd480;
    view_limit     = 16'd256;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels under the reset view
    rows = '{
      '{16'd320, 16'd240, 1, 16'd256, 8'd0},        // view center is interior
      '{16'd0, 16'd0, 0, 0, 0},
      '{16'd639, 16'd479, 0, 0, 0},
      '{16'd65535, 16'd65535, 0, 0, 0},             // far point saturates
      '{16'd0, 16'd65535, 0, 0, 0},
      '{16'd65535, 16'd0, 0, 0, 0},
      '{16'd64, 16'd240, 0, 0, 0},                  // real axis near -2
      '{16'd352, 16'd240, 0, 0, 0},
      '{16'd300, 16'd300, 0, 0, 0},
      '{16'd100, 16'd150, 0, 0, 0},
      '{16'd330, 16'd130, 0, 0, 0},
      '{16'd700, 16'd240, 0, 0, 0}                  // outside the image
    };
    foreach (rows[k]) begin
      typed_res.iter_count  = rows[k].iter;
      typed_res.smooth_frac = rows[k].frac;
      send_pixel(rows[k].px, rows[k].py, rows[k].typed, typed_res);
    end
    end_burst();

    // zero limit counts every point as interior with count zero
    drain_results();
    write_reg(REG_LIMIT, 32'd0);
    write_reg(3'd6, 32'hFFFFFFFF);                  // unknown index, ignored
    write_reg(3'd7, 32'h0);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    typed_res = '0;
    send_pixel(16'd320, 16'd240, 1, typed_res);
    send_pixel(16'd12, 16'd900, 1, typed_res);
    end_burst();

    // zero width and height, step zero: every pixel is the center
    set_view(32'hF8000000, 32'h10000000, 32'd0, 32'd0, 32'd0, 32'd64);
    send_pixel(16'd0, 16'd0, 0, '0);
    send_pixel(16'd5, 16'd7, 0, '0);
    end_burst();

    // extremes: corners of the plane, maximum step and limit, all escape
    for (int ph = 0; ph < 2; ph++) begin
      set_view(ph ? 32'h7FFFFFFF : 32'h80000000, ph ? 32'h7FFFFFFF : 32'h80000000,
               32'h7FFFFFFF, 32'd65535, 32'd1, 32'd65535);
      for (int k = 0; k < 40; k++)
        send_pixel(16'($urandom()), 16'($urandom()), 0, '0);
      end_burst();
    end

    // random views around the set, mostly small limits
    for (int ph = 0; ph < 12; ph++) begin
      cr  = 32'($urandom_range(0, 805306368)) - 32'd590558003;
      ci  = 32'($urandom_range(0, 644245094)) - 32'd322122547;
      st  = $urandom_range(1 << 14, 1 << 22);
      w   = $urandom_range(1, 400);
      h   = $urandom_range(1, 400);
      lim = (ph == 11) ? 32'd256 : 32'(lim_pick[$urandom_range(0, 6)]);
      if (ph == 10) lim = $urandom_range(1, 100);
      if (ph == 9) begin
        cr = $urandom();
        ci = $urandom();
        st = $urandom() >> 1;
        w  = 16'($urandom());
        h  = 16'($urandom());
      end
      set_view(cr, ci, st, 32'(w), 32'(h), lim);
      for (int k = 0; k < ((ph == 11) ? 40 : 80); k++) begin
        if ($urandom_range(0, 9) < 8) begin
          px = $urandom_range(0, w);
          py = $urandom_range(0, h);
        end else begin
          px = 16'($urandom());
          py = 16'($urandom());
        end
        send_pixel(px, py, 0, '0);
      end
      end_burst();
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mbe_frac.sv
rtl/mandelbrot_escape_smooth.sv
tb/tb.sv
